[design/crib_drag_window_checker_top_assert.svh]
// Assertion macros for the crib drag window checker.
// Expects clk and rst_n in the scope of each use.
`ifndef CRIB_DRAG_WINDOW_CHECKER_TOP_ASSERT_SVH
`define CRIB_DRAG_WINDOW_CHECKER_TOP_ASSERT_SVH

// hold cond at every edge outside reset
`define CDWC_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define CDWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/cdwc_pkg.sv]
// Shared constants and types for the crib drag window checker.
// No dependencies; imported by every module of the block.
package cdwc_pkg;

  localparam int CRIB_MAX    = 8;
  localparam int POS_BITS    = 16;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = $clog2(CRIB_MAX + 1);
  localparam int IDX_W       = (CRIB_MAX > 1) ? $clog2(CRIB_MAX) : 1;
  localparam int MATCH_W     = 16;
  localparam int PLAIN_W     = 64;
  localparam int CFG_LEN_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = MATCH_W + PLAIN_W;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  localparam logic [CFG_ADDR_W-1:0] REG_CRIB_BYTES  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_CRIB_LENGTH = 1'b1;

  typedef struct packed {
    logic               ok;
    logic [BYTE_W-1:0]  plain;
  } lane_res_t;

  typedef struct packed {
    logic               valid;
    logic [MATCH_W-1:0] pos;
  } cand_t;

endpackage

[design/cdwc_lane.sv]
// One checking lane: XOR of a window byte with a crib byte and the
// printable-character test. Depends on cdwc_pkg.
module cdwc_lane (
  input  logic [cdwc_pkg::BYTE_W-1:0] win_byte,
  input  logic [cdwc_pkg::BYTE_W-1:0] crib_byte,
  input  logic                        active,
  output cdwc_pkg::lane_res_t         res
);
  import cdwc_pkg::*;

  function automatic logic byte_ok(input logic [BYTE_W-1:0] c);
    logic r;
    r = (c == 8'd32) || (c == 8'd33) || (c == 8'd46) || (c == 8'd58) ||
        (c == 8'd59) || (c == 8'd63) ||
        ((c >= 8'd65) && (c <= 8'd90)) ||
        ((c >= 8'd97) && (c <= 8'd122)) ||
        ((c >= 8'd48) && (c <= 8'd57));
    return r;
  endfunction

  logic [BYTE_W-1:0] p;

  assign p         = win_byte ^ crib_byte;
  assign res.ok    = !active || byte_ok(p);
  assign res.plain = active ? p : '0;

endmodule

[design/cdwc_merge.sv]
// Merge stage: combines the lane verdicts into one result and holds it in
// an output register with a skid slot. Depends on cdwc_pkg and the macros.
module cdwc_merge (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  cdwc_pkg::cand_t                           cand,
  input  cdwc_pkg::lane_res_t [cdwc_pkg::CRIB_MAX-1:0] lanes,
  output logic                                      in_ready,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [cdwc_pkg::OUT_TDATA_W-1:0]          out_data
);
  import cdwc_pkg::*;
  `include "crib_drag_window_checker_top_assert.svh"

  logic                   all_ok;
  logic                   hit;
  logic                   pop;
  logic [PLAIN_W-1:0]     plain;
  logic [OUT_TDATA_W-1:0] word;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [OUT_TDATA_W-1:0] skid_data_r, skid_data_nxt;

  always_comb begin
    all_ok = 1'b1;
    plain  = '0;
    for (int j = 0; j < CRIB_MAX; j++) begin
      all_ok = all_ok & lanes[j].ok;
      plain[j*BYTE_W +: BYTE_W] = lanes[j].plain;
    end
  end

  assign hit  = push && cand.valid && all_ok;
  assign word = {plain, cand.pos};
  assign pop  = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (hit) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = word;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = word;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CDWC_ASSERT_NOW(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid full, output empty")
  `CDWC_ASSERT_NEXT(a_stall_keeps_out, out_valid_r && !out_ready, out_valid_r, "stalled request lost")
  `CDWC_ASSERT_NEXT(a_stall_fills_skid, hit && out_valid_r && !out_ready, skid_valid_r, "hit not parked in skid")

endmodule

[design/crib_drag_window_checker_top.sv]
// Crib drag window checker: XOR window of two ciphertexts, eight parallel lanes
// test window XOR crib for printable text. Depends on cdwc_pkg, cdwc_lane, cdwc_merge.
// A match is registered in the output register, or in the skid slot on a stall.
// Throughput: one request per cycle while the skid is empty; combinational lanes feed
// the output register and its skid slot. Synchronous active-low reset clears the
// window, fill count, position and output buffer; crib resets to 0, length to 1.
module crib_drag_window_checker_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cdwc_pkg::IN_TDATA_W-1:0]    in_tdata,   // cipher_a_byte, cipher_b_byte
  input  logic                               in_tuser,   // stream_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cdwc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // match_position, plain_window
  input  logic                               cfg_we,
  input  logic [cdwc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cdwc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cdwc_pkg::*;
  `include "crib_drag_window_checker_top_assert.svh"

  logic [CFG_DATA_W-1:0] crib_r;
  logic [CFG_LEN_W-1:0]  crib_len_r;

  logic [CRIB_MAX-1:0][BYTE_W-1:0] win_r, win_nxt;
  logic [LEN_W-1:0]                fill_r, fill_nxt, fill_base;
  logic [POS_BITS-1:0]             pos_r, pos_nxt, here;

  logic                            accept;
  logic                            start;
  logic [LEN_W-1:0]                len;
  cand_t                           cand;
  lane_res_t [CRIB_MAX-1:0]        lanes;

  assign accept = in_tvalid && in_tready;
  assign start  = in_tuser;

  always_comb begin
    if (crib_len_r == '0) begin
      len = LEN_W'(1);
    end else if (crib_len_r > CFG_LEN_W'(CRIB_MAX)) begin
      len = LEN_W'(CRIB_MAX);
    end else begin
      len = LEN_W'(crib_len_r);
    end
  end

  always_comb begin
    win_nxt[0] = in_tdata[BYTE_W-1:0] ^ in_tdata[2*BYTE_W-1:BYTE_W];
    for (int k = 1; k < CRIB_MAX; k++) begin
      win_nxt[k] = start ? '0 : win_r[k-1];
    end
    fill_base = start ? '0 : fill_r;
    fill_nxt  = (fill_base < LEN_W'(CRIB_MAX)) ? fill_base + LEN_W'(1) : fill_base;
    here      = start ? '0 : pos_r;
    pos_nxt   = (here < POS_MAX) ? here + POS_BITS'(1) : here;
  end

  assign cand.valid = (fill_nxt >= len);
  assign cand.pos   = MATCH_W'(here - POS_BITS'(len) + POS_BITS'(1));

  for (genvar j = 0; j < CRIB_MAX; j++) begin : g_lane
    logic [IDX_W-1:0] idx;
    logic             active;
    assign idx    = IDX_W'(len - LEN_W'(j) - LEN_W'(1));
    assign active = LEN_W'(j) < len;
    cdwc_lane u_lane (
      .win_byte  (win_nxt[idx]),
      .crib_byte (crib_r[j*BYTE_W +: BYTE_W]),
      .active    (active),
      .res       (lanes[j])
    );
  end

  cdwc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .cand      (cand),
    .lanes     (lanes),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crib_r     <= '0;
      crib_len_r <= CFG_LEN_W'(1);
      win_r      <= '0;
      fill_r     <= '0;
      pos_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CRIB_BYTES:  crib_r     <= cfg_wdata;
          REG_CRIB_LENGTH: crib_len_r <= cfg_wdata[CFG_LEN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        win_r  <= win_nxt;
        fill_r <= fill_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  `CDWC_ASSERT_NOW(a_fill_bound, fill_r <= LEN_W'(CRIB_MAX), "fill count beyond window")
  `CDWC_ASSERT_NEXT(a_start_pos, accept && start, pos_r == POS_BITS'(1), "stream start not at offset 0")
  `CDWC_ASSERT_NEXT(a_start_fill, accept && start, fill_r == LEN_W'(1), "stream start kept old bytes")

endmodule

[tb/crib_drag_window_checker_top_tb.sv]
// Self-checking bench for crib_drag_window_checker_top: a table of directed requests, then
// random phases of planted plaintext runs and noise under changing crib settings.
// Depends on cdwc_pkg and the block's RTL; predicts matches in-bench but for typed rows.
module crib_drag_window_checker_top_tb;
  import cdwc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 3;
  localparam int MAX_SHOWN   = 40;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int DIR_ROWS    = 26;

  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_QUERY = "?";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UZ    = "Z";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LZ    = "z";

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [PLAIN_W-1:0] plain;
    logic [MATCH_W-1:0] position;
  } match_t;

  typedef struct packed {
    logic   typed;
    logic   hit;
    match_t want;
  } row_note_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    logic [7:0]            a;
    logic [7:0]            b;
    logic                  start;
    logic                  typed;
    logic                  hit;
    logic [MATCH_W-1:0]    pos;
    logic [PLAIN_W-1:0]    plain;
  } dir_row_t;

  localparam row_note_t UNTYPED = '0;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // cipher_a_byte, cipher_b_byte
  logic                   in_tuser;   // stream_start
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // match_position, plain_window
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  logic [7:0]           win_bytes [CRIB_MAX];
  logic [3:0]           fill_cnt;
  logic [POS_BITS-1:0]  next_pos;
  logic [PLAIN_W-1:0]   crib_word;
  logic [CFG_LEN_W-1:0] crib_len_reg;

  match_t    pending_matches [$];
  row_note_t request_notes [$];
  int        err_count   = 0;
  int        cycle_count = 0;
  bit        idle_on     = 1'b1;
  bit        hold_pending = 1'b0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hFF, 8'hDF, 1'b0, 1'b1, 1'b1, 16'd1, 64'h20},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'h41, 8'h00, 1'b0, 1'b1, 1'b1, 16'd3, 64'h41},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'h00, 8'h7A, 1'b0, 1'b1, 1'b1, 16'd4, 64'h7A},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'h80, 8'hFF, 1'b0, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'h30, 8'h09, 1'b0, 1'b1, 1'b1, 16'd6, 64'h39},
    '{ROW_CFG,  REG_CRIB_LENGTH, 64'h0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_CFG,  REG_CRIB_BYTES,  64'h1, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'h21, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_CFG,  REG_CRIB_BYTES,  '1,    8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_CFG,  REG_CRIB_LENGTH, 64'hF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hBE, 8'h00, 1'b1, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hBE, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hBE, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hBE, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hBE, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hBE, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hBE, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hBE, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0,
      64'h4141_4141_4141_4141},
    '{ROW_CFG,  REG_CRIB_LENGTH, 64'h3, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'hC0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_CFG,  REG_CRIB_BYTES,  64'h0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_CFG,  REG_CRIB_LENGTH, 64'h8, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'h7F, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 64'h0},
    '{ROW_ITEM, REG_CRIB_BYTES,  64'h0, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, 16'd0, 64'h0}
  };

  crib_drag_window_checker_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_len(input logic [CFG_LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > CRIB_MAX) return CRIB_MAX;
    return int'(l);
  endfunction

  function automatic bit is_text_byte(input logic [7:0] c);
    return (c inside {CH_SPACE, CH_BANG, CH_DOT, CH_COLON, CH_SEMI, CH_QUERY}) ||
           (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic logic [7:0] rand_text_byte();
    int r;
    r = $urandom_range(0, 67);
    if (r < 10) return CH_0 + 8'(r);
    if (r < 36) return CH_UA + 8'(r - 10);
    if (r < 62) return CH_LA + 8'(r - 36);
    case (r)
      62:      return CH_SPACE;
      63:      return CH_BANG;
      64:      return CH_DOT;
      65:      return CH_COLON;
      66:      return CH_SEMI;
      default: return CH_QUERY;
    endcase
  endfunction

  function automatic int idle_stretch();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // shift one XOR byte in and test the newest window against the crib
  function automatic void crib_window_step(input logic [7:0] a, input logic [7:0] b,
                                           input logic start, output bit hit,
                                           output match_t res);
    int                  len;
    logic [POS_BITS-1:0] here;
    logic [7:0]          p;
    bit                  ok;
    len = eff_len(crib_len_reg);
    hit = 1'b0;
    res = '0;
    if (start) begin
      foreach (win_bytes[k]) win_bytes[k] = '0;
      fill_cnt = '0;
      next_pos = '0;
    end
    for (int k = CRIB_MAX - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = a ^ b;
    if (fill_cnt < CRIB_MAX) fill_cnt++;
    here = next_pos;
    if (next_pos != POS_MAX) next_pos++;
    if (fill_cnt < len) return;
    ok = 1'b1;
    for (int j = 0; j < len; j++) begin
      p = win_bytes[len-1-j] ^ crib_word[8*j +: 8];
      if (!is_text_byte(p)) ok = 1'b0;
      res.plain[8*j +: 8] = p;
    end
    res.position = MATCH_W'(int'(here) - len + 1);
    hit = ok;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_SHOWN) $display("cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  always @(posedge clk) begin : watch
    match_t    got;
    match_t    want;
    match_t    calc;
    row_note_t note;
    bit        hit;
    if (!rst_n) begin
      foreach (win_bytes[k]) win_bytes[k] = '0;
      fill_cnt     = '0;
      next_pos     = '0;
      crib_word    = '0;
      crib_len_reg = CFG_LEN_W'(1);
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CRIB_BYTES:  crib_word = cfg_wdata;
          REG_CRIB_LENGTH: crib_len_reg = cfg_wdata[CFG_LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_matches.size() == 0) begin
          report_mismatch($sformatf("unexpected match pos %0d plain %h",
                                    got.position, got.plain));
        end else begin
          want = pending_matches.pop_front();
          if (got.position !== want.position)
            report_mismatch($sformatf("match_position %0d, want %0d",
                                      got.position, want.position));
          if (got.plain !== want.plain)
            report_mismatch($sformatf("plain_window %h, want %h", got.plain, want.plain));
        end
      end
      if (in_tvalid && in_tready) begin
        note = request_notes.pop_front();
        crib_window_step(in_tdata[7:0], in_tdata[15:8], in_tuser, hit, calc);
        if (note.typed) begin
          hit  = note.hit;
          calc = note.want;
        end
        if (hit) pending_matches.push_back(calc);
      end
    end
  end

  initial begin : receiver
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = idle_stretch();
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic start,
                           input row_note_t note);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_stretch() : 0;
    request_notes.push_back(note);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    row_note_t             note;
    logic [CFG_DATA_W-1:0] crib;
    logic [CFG_DATA_W-1:0] len_word;
    logic [7:0]            a;
    int                    run_len;
    int                    sent;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        write_reg(dir_table[i].addr, dir_table[i].wdata);
      end else begin
        note = '{dir_table[i].typed, dir_table[i].hit,
                 '{dir_table[i].plain, dir_table[i].pos}};
        send_pair(dir_table[i].a, dir_table[i].b, dir_table[i].start, note);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 5)
        0:       crib = '0;
        1:       crib = '1;
        default: crib = {$urandom(), $urandom()};
      endcase
      case ($urandom_range(0, 4))
        0:       len_word = 64'h0;
        1:       len_word = 64'h8;
        2:       len_word = 64'hF;
        default: len_word = {$urandom(), $urandom()};
      endcase
      if (ph == 0) begin
        crib     = '0;
        len_word = 64'h1;
      end
      write_reg(REG_CRIB_BYTES, crib);
      write_reg(REG_CRIB_LENGTH, len_word);
      idle_on = (ph % 4 != 3);
      if (ph == 0) hold_pending = 1'b1;
      run_len = eff_len(len_word[CFG_LEN_W-1:0]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          for (int j = 0; j < run_len; j++) begin
            a = $urandom_range(0, 255);
            send_pair(a, a ^ crib[8*j +: 8] ^ rand_text_byte(),
                      sent == 0 || (j == 0 && $urandom_range(0, 19) == 0), UNTYPED);
            sent++;
          end
        end else begin
          send_pair($urandom_range(0, 255), $urandom_range(0, 255),
                    sent == 0 || $urandom_range(0, 49) == 0, UNTYPED);
          sent++;
        end
      end
    end
    idle_on = 1'b1;

    drain();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/cdwc_pkg.sv
design/cdwc_lane.sv
design/cdwc_merge.sv
design/crib_drag_window_checker_top.sv
tb/crib_drag_window_checker_top_tb.sv
